// File: design/rstm_pkg.sv
// ----------------------------------------------------------------------------
// rstm_pkg: shared constants for the range add / range sum tree
// Opcodes, data width and default sizing used by the tree, the multiplier and the bench.
// ----------------------------------------------------------------------------
package rstm_pkg;

  localparam int unsigned DATA_W   = 64;
  localparam int unsigned SIZE_DEF = 1024;
  localparam int unsigned REG_W    = 11;
  localparam int unsigned POS_W    = 11;

  localparam logic [REG_W-1:0] SIZE_RST = 11'd1024;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_ADD  = 2'd1;
  localparam logic [1:0] OP_SUM  = 2'd2;

endpackage

// File: design/rstm_ram.sv
// ----------------------------------------------------------------------------
// rstm_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module rstm_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/rstm_mul.sv
// ----------------------------------------------------------------------------
// rstm_mul: 64-bit by element-count multiplier, wrapping
// Splits the 64-bit operand in two 32-bit halves, one partial product a
// cycle, then combines; result valid with done_o after the low, high and sum phases.
// ----------------------------------------------------------------------------
module rstm_mul #(
  parameter int unsigned CNT_W = 11
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [rstm_pkg::DATA_W-1:0] a_i,
  input  logic [CNT_W-1:0]           b_i,
  output logic                       done_o,
  output logic [rstm_pkg::DATA_W-1:0] prod_o
);

  localparam int unsigned PROD_W = 32 + CNT_W;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_LO   = 2'd1;
  localparam logic [1:0] PH_HI   = 2'd2;
  localparam logic [1:0] PH_SUM  = 2'd3;

  logic [1:0]                  phase_q, phase_d;
  logic                        done_q, done_d;
  logic [rstm_pkg::DATA_W-1:0] a_q, prod_q;
  logic [CNT_W-1:0]            b_q;
  logic [PROD_W-1:0]           lo_q;
  logic [31:0]                 hi_q;
  logic [PROD_W-1:0]           hi_full;

  assign hi_full = PROD_W'(a_q[63:32]) * PROD_W'(b_q);

  always_comb begin
    phase_d = phase_q;
    done_d  = 1'b0;
    unique case (phase_q)
      PH_IDLE: if (start_i) phase_d = PH_LO;
      PH_LO:   phase_d = PH_HI;
      PH_HI:   phase_d = PH_SUM;
      PH_SUM: begin
        phase_d = PH_IDLE;
        done_d  = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && phase_q == PH_IDLE) begin
      a_q <= a_i;
      b_q <= b_i;
    end
    if (phase_q == PH_LO) lo_q <= PROD_W'(a_q[31:0]) * PROD_W'(b_q);
    if (phase_q == PH_HI) hi_q <= hi_full[31:0];
    if (phase_q == PH_SUM) prod_q <= 64'(lo_q) + {hi_q, 32'd0};
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

endmodule

// File: design/range_add_range_sum_tree.sv
// ----------------------------------------------------------------------------
// range_add_range_sum_tree: lazy segment tree, range add and range sum
// Work: each tree level on a path takes a node read, a push down to both
//   children through the multiplier and a rebuild. Ignored items and
//   flagged queries are answered or dropped without walking the tree.
// Handshake: a new item is taken once busy_o drops. A query result shows
//   for one cycle on result_valid_o; the receiver cannot stall it.
// Reset: clears control, sets size_in_use to 1024, then sweeps all 4*SIZE
//   nodes to zero with busy_o high.
// ----------------------------------------------------------------------------
module range_add_range_sum_tree #(
  parameter int unsigned SIZE = rstm_pkg::SIZE_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [1:0]                op_i,
  input  logic [10:0]               range_left_i,
  input  logic [10:0]               range_right_i,
  input  logic signed [31:0]        add_value_i,
  input  logic signed [63:0]        element_value_i,
  input  logic                      size_in_use_we_i,
  input  logic [10:0]               size_in_use_i,
  output logic                      result_valid_o,
  output logic signed [63:0]        range_sum_o,
  output logic                      bad_range_o
);

  // node store depth and index / position widths
  localparam int unsigned DEPTH = 4 * SIZE;
  localparam int unsigned KW    = $clog2(DEPTH);
  localparam int unsigned PW    = $clog2(SIZE + 1);
  localparam int unsigned CW    = (PW > 11) ? PW : 11;
  localparam int unsigned DW    = rstm_pkg::DATA_W;

  // sequencer states
  localparam logic [3:0] ST_CLEAR   = 4'd0;
  localparam logic [3:0] ST_IDLE    = 4'd1;
  localparam logic [3:0] ST_NODE    = 4'd2;
  localparam logic [3:0] ST_NODE_D  = 4'd3;
  localparam logic [3:0] ST_SP2     = 4'd4;
  localparam logic [3:0] ST_DECIDE  = 4'd5;
  localparam logic [3:0] ST_GO_L    = 4'd6;
  localparam logic [3:0] ST_GO_R    = 4'd7;
  localparam logic [3:0] ST_END     = 4'd8;
  localparam logic [3:0] ST_RB      = 4'd9;
  localparam logic [3:0] ST_RB1     = 4'd10;
  localparam logic [3:0] ST_RB2     = 4'd11;
  localparam logic [3:0] ST_AP_RD   = 4'd12;
  localparam logic [3:0] ST_AP_MUL  = 4'd13;
  localparam logic [3:0] ST_AP_WAIT = 4'd14;
  localparam logic [3:0] ST_AP_WR   = 4'd15;

  // walk modes: single path from the root, then left and right boundary paths
  localparam logic [1:0] MODE_TOP   = 2'd0;
  localparam logic [1:0] MODE_LEFT  = 2'd1;
  localparam logic [1:0] MODE_RIGHT = 2'd2;

  logic [3:0]    state_q, state_d, ret_q, ret_d;
  logic [1:0]    mode_q, mode_d, op_q, op_d;
  logic [KW-1:0] k_q, k_d, split_q, split_d, rk_q, rk_d, j_q, j_d, up_q, up_d;
  logic [KW-1:0] clr_q, clr_d;
  logic [PW-1:0] l_q, l_d, r_q, r_d, lo_q, lo_d, hi_q, hi_d;
  logic [PW-1:0] rl_q, rl_d, rr_q, rr_d, rhi_q, rhi_d, cnt_q, cnt_d;
  logic [DW-1:0] v_q, v_d, ev_q, ev_d, pk_q, pk_d, x_q, x_d;
  logic [DW-1:0] ap_p_q, ap_p_d, ap_s_q, ap_s_d, acc_q, acc_d, sa_q, sa_d;
  logic [10:0]   size_q;
  logic          res_v_q, res_v_d, bad_q, bad_d;
  logic [DW-1:0] res_sum_q, res_sum_d;

  // RAM entry: {pending add, node sum}
  logic            ram_we;
  logic [KW-1:0]   ram_waddr, ram_raddr;
  logic [2*DW-1:0] ram_wdata, ram_rdata;
  logic [DW-1:0]   rd_pend, rd_sum;

  logic          mul_start, mul_done;
  logic [DW-1:0] mul_prod, new_sum;

  assign rd_pend = ram_rdata[2*DW-1:DW];
  assign rd_sum  = ram_rdata[DW-1:0];
  assign new_sum = ap_s_q + mul_prod;

  // effective size: size_in_use clamped to 1..SIZE
  logic [CW-1:0] size_c, n_c, lo_c, hi_c;
  logic          q_ok, ld_ok;
  assign size_c = CW'(size_q);
  always_comb begin
    priority if (size_c == '0)        n_c = CW'(1);
    else if (size_c > CW'(SIZE))      n_c = CW'(SIZE);
    else                              n_c = size_c;
  end
  assign lo_c  = CW'(range_left_i);
  assign hi_c  = CW'(range_right_i);
  assign q_ok  = (lo_c != '0) && (lo_c <= hi_c) && (hi_c <= n_c);
  assign ld_ok = (lo_c != '0) && (lo_c <= n_c);

  // split point and child indices of the current node
  logic [PW:0]   lr_sum;
  logic [PW-1:0] mid, cnt_all, cnt_left, cnt_right;
  logic [KW-1:0] k_lc, k_rc, up_lc, up_rc, rb_limit;
  logic          full_hit;
  assign lr_sum    = {1'b0, l_q} + {1'b0, r_q};
  assign mid       = lr_sum[PW:1];
  assign cnt_all   = r_q - l_q + PW'(1);
  assign cnt_left  = mid - l_q + PW'(1);
  assign cnt_right = r_q - mid;
  assign k_lc      = {k_q[KW-2:0], 1'b0};
  assign k_rc      = {k_q[KW-2:0], 1'b1};
  assign up_lc     = {up_q[KW-2:0], 1'b0};
  assign up_rc     = {up_q[KW-2:0], 1'b1};
  assign full_hit  = (lo_q == l_q) && (hi_q == r_q);
  // left chain rebuild stops below the split node; final chain runs to the root
  assign rb_limit  = (mode_q == MODE_LEFT) ? split_q : '0;

  logic [DW-1:0] op_x;
  assign op_x = (op_q == rstm_pkg::OP_ADD) ? v_q : '0;

  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    mode_d    = mode_q;
    op_d      = op_q;
    k_d       = k_q;
    split_d   = split_q;
    rk_d      = rk_q;
    j_d       = j_q;
    up_d      = up_q;
    clr_d     = clr_q;
    l_d       = l_q;
    r_d       = r_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    rl_d      = rl_q;
    rr_d      = rr_q;
    rhi_d     = rhi_q;
    cnt_d     = cnt_q;
    v_d       = v_q;
    ev_d      = ev_q;
    pk_d      = pk_q;
    x_d       = x_q;
    ap_p_d    = ap_p_q;
    ap_s_d    = ap_s_q;
    acc_d     = acc_q;
    sa_d      = sa_q;
    res_v_d   = 1'b0;
    bad_d     = bad_q;
    res_sum_d = res_sum_q;
    ram_we    = 1'b0;
    ram_waddr = k_q;
    ram_wdata = '0;
    ram_raddr = k_q;
    mul_start = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + KW'(1);
        if (clr_q == KW'(DEPTH - 1)) state_d = ST_IDLE;
      end

      ST_IDLE: begin
        if (start_i) begin
          op_d   = op_i;
          lo_d   = PW'(lo_c);
          hi_d   = (op_i == rstm_pkg::OP_LOAD) ? PW'(lo_c) : PW'(hi_c);
          v_d    = {{32{add_value_i[31]}}, add_value_i};
          ev_d   = element_value_i;
          k_d    = KW'(1);
          l_d    = PW'(1);
          r_d    = PW'(n_c);
          mode_d = MODE_TOP;
          acc_d  = '0;
          priority if (op_i == rstm_pkg::OP_LOAD) begin
            if (ld_ok) state_d = ST_NODE;
          end else if (op_i == rstm_pkg::OP_ADD) begin
            if (q_ok) state_d = ST_NODE;
          end else if (op_i == rstm_pkg::OP_SUM) begin
            if (q_ok) begin
              state_d = ST_NODE;
            end else begin
              // flagged query: answer at once
              res_v_d   = 1'b1;
              res_sum_d = '0;
              bad_d     = 1'b1;
            end
          end else begin
            state_d = ST_IDLE;
          end
        end
      end

      ST_NODE: begin
        ram_raddr = k_q;
        state_d   = ST_NODE_D;
      end

      ST_NODE_D: begin
        if (full_hit) begin
          if (op_q == rstm_pkg::OP_LOAD) begin
            ram_we    = 1'b1;
            ram_waddr = k_q;
            ram_wdata = {{DW{1'b0}}, ev_q};
            state_d   = ST_END;
          end else begin
            j_d     = k_q;
            x_d     = op_x;
            cnt_d   = cnt_all;
            ret_d   = ST_END;
            state_d = ST_AP_RD;
          end
        end else begin
          // push pending add down: clear it here, apply to both children
          ram_we    = 1'b1;
          ram_waddr = k_q;
          ram_wdata = {{DW{1'b0}}, rd_sum};
          pk_d      = rd_pend;
          j_d       = k_lc;
          x_d       = rd_pend;
          cnt_d     = cnt_left;
          ret_d     = ST_SP2;
          state_d   = ST_AP_RD;
        end
      end

      ST_SP2: begin
        j_d     = k_rc;
        x_d     = pk_q;
        cnt_d   = cnt_right;
        ret_d   = ST_DECIDE;
        state_d = ST_AP_RD;
      end

      ST_DECIDE: begin
        priority if (mid < lo_q) begin
          k_d     = k_rc;
          l_d     = mid + PW'(1);
          state_d = ST_NODE;
        end else if (hi_q <= mid) begin
          k_d     = k_lc;
          r_d     = mid;
          state_d = ST_NODE;
        end else if (mode_q == MODE_TOP) begin
          // split: keep the right branch for later, walk the left one
          split_d = k_q;
          rk_d    = k_rc;
          rl_d    = mid + PW'(1);
          rr_d    = r_q;
          rhi_d   = hi_q;
          mode_d  = MODE_LEFT;
          k_d     = k_lc;
          r_d     = mid;
          hi_d    = mid;
          state_d = ST_NODE;
        end else if (mode_q == MODE_LEFT) begin
          // right child lies fully inside the range
          j_d     = k_rc;
          x_d     = op_x;
          cnt_d   = cnt_right;
          ret_d   = ST_GO_L;
          state_d = ST_AP_RD;
        end else begin
          // left child lies fully inside the range
          j_d     = k_lc;
          x_d     = op_x;
          cnt_d   = cnt_left;
          ret_d   = ST_GO_R;
          state_d = ST_AP_RD;
        end
      end

      ST_GO_L: begin
        k_d     = k_lc;
        r_d     = mid;
        hi_d    = mid;
        state_d = ST_NODE;
      end

      ST_GO_R: begin
        k_d     = k_rc;
        l_d     = mid + PW'(1);
        lo_d    = mid + PW'(1);
        state_d = ST_NODE;
      end

      ST_END: begin
        if (op_q == rstm_pkg::OP_SUM) begin
          if (mode_q == MODE_LEFT) begin
            mode_d  = MODE_RIGHT;
            k_d     = rk_q;
            l_d     = rl_q;
            r_d     = rr_q;
            lo_d    = rl_q;
            hi_d    = rhi_q;
            state_d = ST_NODE;
          end else begin
            res_v_d   = 1'b1;
            res_sum_d = acc_q;
            bad_d     = 1'b0;
            state_d   = ST_IDLE;
          end
        end else begin
          up_d    = k_q >> 1;
          state_d = ST_RB;
        end
      end

      ST_RB: begin
        if (up_q == rb_limit) begin
          if (mode_q == MODE_LEFT) begin
            mode_d  = MODE_RIGHT;
            k_d     = rk_q;
            l_d     = rl_q;
            r_d     = rr_q;
            lo_d    = rl_q;
            hi_d    = rhi_q;
            state_d = ST_NODE;
          end else begin
            state_d = ST_IDLE;
          end
        end else begin
          ram_raddr = up_lc;
          state_d   = ST_RB1;
        end
      end

      ST_RB1: begin
        sa_d      = rd_sum;
        ram_raddr = up_rc;
        state_d   = ST_RB2;
      end

      ST_RB2: begin
        ram_we    = 1'b1;
        ram_waddr = up_q;
        ram_wdata = {{DW{1'b0}}, sa_q + rd_sum};
        up_d      = up_q >> 1;
        state_d   = ST_RB;
      end

      // node update: pending += x, sum += x * cnt
      ST_AP_RD: begin
        ram_raddr = j_q;
        state_d   = ST_AP_MUL;
      end

      ST_AP_MUL: begin
        ap_p_d    = rd_pend;
        ap_s_d    = rd_sum;
        mul_start = 1'b1;
        state_d   = ST_AP_WAIT;
      end

      ST_AP_WAIT: begin
        if (mul_done) state_d = ST_AP_WR;
      end

      ST_AP_WR: begin
        ram_we    = 1'b1;
        ram_waddr = j_q;
        ram_wdata = {ap_p_q + x_q, new_sum};
        // only nodes inside the range count; push-down updates do not
        if (op_q == rstm_pkg::OP_SUM && ret_q != ST_SP2 && ret_q != ST_DECIDE) begin
          acc_d = acc_q + new_sum;
        end
        state_d   = ret_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      ret_q   <= ST_IDLE;
      mode_q  <= MODE_TOP;
      op_q    <= rstm_pkg::OP_LOAD;
      clr_q   <= '0;
      size_q  <= rstm_pkg::SIZE_RST;
      res_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      mode_q  <= mode_d;
      op_q    <= op_d;
      clr_q   <= clr_d;
      res_v_q <= res_v_d;
      if (size_in_use_we_i) size_q <= size_in_use_i;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q       <= k_d;
    split_q   <= split_d;
    rk_q      <= rk_d;
    j_q       <= j_d;
    up_q      <= up_d;
    l_q       <= l_d;
    r_q       <= r_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    rl_q      <= rl_d;
    rr_q      <= rr_d;
    rhi_q     <= rhi_d;
    cnt_q     <= cnt_d;
    v_q       <= v_d;
    ev_q      <= ev_d;
    pk_q      <= pk_d;
    x_q       <= x_d;
    ap_p_q    <= ap_p_d;
    ap_s_q    <= ap_s_d;
    acc_q     <= acc_d;
    sa_q      <= sa_d;
    bad_q     <= bad_d;
    res_sum_q <= res_sum_d;
  end

  rstm_ram #(
    .WIDTH(2 * DW),
    .DEPTH(DEPTH)
  ) u_node_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  rstm_mul #(
    .CNT_W(PW)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (x_q),
    .b_i    (cnt_q),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = res_v_q;
  assign range_sum_o    = res_sum_q;
  assign bad_range_o    = bad_q;

endmodule

// File: tb/range_add_range_sum_tree_tb.sv
// ----------------------------------------------------------------------------
// range_add_range_sum_tree_tb: self-checking bench for the lazy sum tree
// Loads, range adds and range sum queries are sent under several tree sizes
// and idle patterns. A tree model with pending adds predicts each query
// result, and the monitor checks every result strobe against it.
// ----------------------------------------------------------------------------
module range_add_range_sum_tree_tb;

  localparam int unsigned NODES      = 4 * rstm_pkg::SIZE_DEF;
  localparam logic [1:0]  OP_NONE    = 2'd3;   // unused opcode, no effect
  localparam int          SETTLE_CYC = 600;    // longer than one item
  localparam longint      CYC_LIMIT  = 40_000_000;

  typedef struct packed {
    logic [1:0]         op;
    logic [10:0]        left;
    logic [10:0]        right;
    logic signed [31:0] addv;
    logic signed [63:0] elemv;
  } item_t;

  typedef struct packed {
    logic [63:0] sum;
    logic        bad;
  } sum_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic [1:0]         op_i = rstm_pkg::OP_LOAD;
  logic [10:0]        range_left_i = '0;
  logic [10:0]        range_right_i = '0;
  logic signed [31:0] add_value_i = '0;
  logic signed [63:0] element_value_i = '0;
  logic               size_in_use_we_i = 1'b0;
  logic [10:0]        size_in_use_i = '0;
  logic               result_valid_o;
  logic signed [63:0] range_sum_o;
  logic               bad_range_o;

  range_add_range_sum_tree dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Model state: node sums, pending adds and the size register.
  bit [63:0]   model_sum  [NODES];
  bit [63:0]   model_pend [NODES];
  logic [10:0] model_size = rstm_pkg::SIZE_RST;

  item_t       pending_items[$];
  sum_result_t expected_sums[$];
  item_t       cur_item;
  int          idle_pct = 0;
  int          n_sent = 0, n_queries = 0, n_checked = 0, n_bad = 0, n_errors = 0;
  longint      cycles = 0;

  function automatic int unsigned tree_n();
    if (model_size < 1) return 1;
    if (model_size > rstm_pkg::SIZE_DEF) return rstm_pkg::SIZE_DEF;
    return 32'(model_size);
  endfunction

  // Hand a node's pending add to both children.
  function automatic void push_down(int unsigned k, int unsigned l, int unsigned r);
    int unsigned m;
    bit [63:0]   p;
    m = (l + r) >> 1;
    if (2 * k + 1 >= NODES) return;
    p = model_pend[k];
    model_pend[2*k]   += p;
    model_pend[2*k+1] += p;
    model_sum[2*k]    += p * 64'(m - l + 1);
    model_sum[2*k+1]  += p * 64'(r - m);
    model_pend[k] = '0;
  endfunction

  function automatic void pull_up(int unsigned k);
    if (2 * k + 1 >= NODES) return;
    model_sum[k] = model_sum[2*k] + model_sum[2*k+1];
  endfunction

  function automatic void tree_add(int unsigned k, int unsigned l, int unsigned r,
                                   int unsigned lo, int unsigned hi, bit [63:0] v);
    int unsigned m;
    if (k >= NODES) return;
    if (lo == l && hi == r) begin
      model_pend[k] += v;
      model_sum[k]  += v * 64'(r - l + 1);
      return;
    end
    push_down(k, l, r);
    m = (l + r) >> 1;
    if (m < lo) tree_add(2*k+1, m+1, r, lo, hi, v);
    else if (m >= hi) tree_add(2*k, l, m, lo, hi, v);
    else begin
      tree_add(2*k+1, m+1, r, m+1, hi, v);
      tree_add(2*k, l, m, lo, m, v);
    end
    pull_up(k);
  endfunction

  function automatic bit [63:0] tree_sum(int unsigned k, int unsigned l, int unsigned r,
                                         int unsigned lo, int unsigned hi);
    int unsigned m;
    if (k >= NODES) return '0;
    if (lo == l && hi == r) return model_sum[k];
    push_down(k, l, r);
    m = (l + r) >> 1;
    if (m < lo) return tree_sum(2*k+1, m+1, r, lo, hi);
    if (hi <= m) return tree_sum(2*k, l, m, lo, hi);
    return tree_sum(2*k+1, m+1, r, m+1, hi) + tree_sum(2*k, l, m, lo, m);
  endfunction

  function automatic void tree_load(int unsigned k, int unsigned l, int unsigned r,
                                    int unsigned pos, bit [63:0] v);
    int unsigned m;
    if (k >= NODES) return;
    if (l == r) begin
      model_sum[k]  = v;
      model_pend[k] = '0;
      return;
    end
    push_down(k, l, r);
    m = (l + r) >> 1;
    if (pos <= m) tree_load(2*k, l, m, pos, v);
    else tree_load(2*k+1, m+1, r, pos, v);
    pull_up(k);
  endfunction

  // Apply one accepted item to the model; queries queue an expected sum.
  function automatic void apply_item(item_t it);
    int unsigned n;
    bit          ok;
    sum_result_t res;
    n  = tree_n();
    ok = (it.left >= 1) && (it.left <= it.right) && (it.right <= n);
    case (it.op)
      rstm_pkg::OP_LOAD:
        if (it.left >= 1 && it.left <= n) tree_load(1, 1, n, 32'(it.left), it.elemv);
      rstm_pkg::OP_ADD:
        if (ok) tree_add(1, 1, n, 32'(it.left), 32'(it.right), 64'($signed(it.addv)));
      rstm_pkg::OP_SUM: begin
        res.sum = ok ? tree_sum(1, 1, n, 32'(it.left), 32'(it.right)) : '0;
        res.bad = !ok;
        expected_sums.push_back(res);
        n_queries++;
        if (!ok) n_bad++;
      end
      default: ;
    endcase
  endfunction

  // Driver: an item is taken when start is high and busy is low.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        apply_item(cur_item);
        n_sent++;
      end
      if (!start_i || !busy_o) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
          cur_item = pending_items.pop_front();
          start_i         <= 1'b1;
          op_i            <= cur_item.op;
          range_left_i    <= cur_item.left;
          range_right_i   <= cur_item.right;
          add_value_i     <= cur_item.addv;
          element_value_i <= cur_item.elemv;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: each strobe is checked against the oldest expected sum.
  always @(posedge clk_i) begin
    sum_result_t want;
    if (result_valid_o) begin
      if (expected_sums.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("ERROR: unexpected result sum=%0d bad=%0b",
                                     range_sum_o, bad_range_o);
      end else begin
        want = expected_sums.pop_front();
        n_checked++;
        if (range_sum_o !== want.sum || bad_range_o !== want.bad) begin
          n_errors++;
          if (n_errors <= 10)
            $display("ERROR: query %0d sum exp %0d got %0d, bad exp %0b got %0b",
                     n_checked, $signed(want.sum), range_sum_o, want.bad, bad_range_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYC_LIMIT) begin
      $display("ERROR: timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Range mostly legal for the current size; sometimes any 11-bit pair.
  function automatic item_t rand_item();
    item_t       it;
    int unsigned n, pick;
    n    = tree_n();
    pick = $urandom_range(99);
    it.op = (pick < 30) ? rstm_pkg::OP_LOAD : (pick < 60) ? rstm_pkg::OP_ADD :
            (pick < 96) ? rstm_pkg::OP_SUM : OP_NONE;
    if ($urandom_range(9) == 0) begin
      it.left  = 11'($urandom);
      it.right = 11'($urandom);
    end else begin
      it.left  = 11'($urandom_range(n, 1));
      it.right = 11'($urandom_range(n, 32'(it.left)));
    end
    it.addv  = ($urandom_range(1) == 0) ? $signed(32'($urandom_range(200)) - 100) : $urandom;
    it.elemv = ($urandom_range(1) == 0) ? 64'($signed(32'($urandom_range(2000)) - 1000))
                                        : {$urandom, $urandom};
    return it;
  endfunction

  function automatic item_t mk(logic [1:0] op, int l, int r,
                               logic [31:0] a, logic [63:0] e);
    item_t it;
    it.op = op; it.left = 11'(l); it.right = 11'(r); it.addv = a; it.elemv = e;
    return it;
  endfunction

  // Block until every queued item is taken and every query answered, then
  // let any trailing add or load finish inside the block.
  task automatic drain();
    while (pending_items.size() > 0 || start_i || expected_sums.size() > 0)
      @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
    while (busy_o) @(negedge clk_i);
  endtask

  task automatic write_size(logic [10:0] v);
    drain();
    @(posedge clk_i);
    size_in_use_we_i <= 1'b1;
    size_in_use_i    <= v;
    @(posedge clk_i);
    size_in_use_we_i <= 1'b0;
    model_size = v;
  endtask

  initial begin
    logic [10:0] sizes [8] = '{11'd1024, 11'd1, 11'd2, 11'd7, 11'd100, 11'd0,
                               11'd2047, 11'd513};
    int          idles [8] = '{0, 79, 79, 14, 0, 79, 14, 0};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: field extremes and each corner at the reset size.
    pending_items.push_back(mk(rstm_pkg::OP_LOAD, 1, 0, 0, 64'h7FFF_FFFF_FFFF_FFFF));
    pending_items.push_back(mk(rstm_pkg::OP_LOAD, 1024, 0, 0, 64'h8000_0000_0000_0000));
    pending_items.push_back(mk(rstm_pkg::OP_SUM, 1, 1024, 0, 0));
    pending_items.push_back(mk(rstm_pkg::OP_ADD, 1, 1024, 32'h8000_0000, 0));
    pending_items.push_back(mk(rstm_pkg::OP_ADD, 3, 700, 32'h7FFF_FFFF, 0));
    pending_items.push_back(mk(rstm_pkg::OP_SUM, 1, 1, 0, 0));
    pending_items.push_back(mk(rstm_pkg::OP_SUM, 1024, 1024, 0, 0));
    pending_items.push_back(mk(rstm_pkg::OP_LOAD, 500, 0, 0, 64'd42)); // pending adds on path
    pending_items.push_back(mk(rstm_pkg::OP_SUM, 2, 1023, 0, 0));
    pending_items.push_back(mk(rstm_pkg::OP_SUM, 0, 5, 0, 0));         // left below one
    pending_items.push_back(mk(rstm_pkg::OP_SUM, 9, 8, 0, 0));         // left above right
    pending_items.push_back(mk(rstm_pkg::OP_SUM, 1, 1025, 0, 0));      // right past size
    pending_items.push_back(mk(rstm_pkg::OP_SUM, 2047, 2047, 0, 0));
    pending_items.push_back(mk(rstm_pkg::OP_ADD, 0, 4, 32'd5, 0));     // ignored adds
    pending_items.push_back(mk(rstm_pkg::OP_ADD, 7, 6, 32'd5, 0));
    pending_items.push_back(mk(rstm_pkg::OP_ADD, 1000, 2047, 32'd5, 0));
    pending_items.push_back(mk(rstm_pkg::OP_LOAD, 0, 0, 0, 64'd9));    // ignored loads
    pending_items.push_back(mk(rstm_pkg::OP_LOAD, 1025, 0, 0, 64'd9));
    pending_items.push_back(mk(OP_NONE, 1, 1024, 32'hFFFF_FFFF, '1));
    pending_items.push_back(mk(rstm_pkg::OP_SUM, 1, 1024, 0, 0));

    // Random phases; each size change happens with the block drained, so
    // the tree contents carry over into a new layout.
    for (int ph = 0; ph < 8; ph++) begin
      write_size(sizes[ph]);
      idle_pct = idles[ph];
      for (int i = 0; i < 230; i++) pending_items.push_back(rand_item());
    end
    drain();

    $display("Sent %0d items, %0d queries, checked %0d sums (%0d flagged ranges)",
             n_sent, n_queries, n_checked, n_bad);
    $display("Sizes covered: 1024, 1, 2, 7, 100, 0, 2047, 513; idle 0/14/79 percent");
    if (n_errors == 0 && expected_sums.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("ERROR: %0d mismatches, %0d results missing", n_errors, expected_sums.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: range_add_range_sum_tree.f
design/rstm_pkg.sv
design/rstm_ram.sv
design/rstm_mul.sv
design/range_add_range_sum_tree.sv
tb/range_add_range_sum_tree_tb.sv
